// ===== src/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	// Operand width used for message, exponent and modulus
	localparam int WORD_BITS = 32;
	// Port width of the data fields and the configuration data
	localparam int FIELD_BITS = 32;
	// Bit counter of the serial multiplier, holds WORD_BITS itself
	localparam int CNT_BITS = $clog2(WORD_BITS + 1);
	// Configuration register index
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BIT,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} state_t;

	// Request to the modular multiplier: result = a * b mod n, with a < n
	typedef struct packed {
		logic                 start;
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
	} mm_req_t;

endpackage

// ===== src/modexp_mm.sv =====
// ----------------------------------------------------------------------------
// modexp_mm
// Bit-serial interleaved modular multiplier. Scans b from its MSB, one bit
// per cycle: r = 2r + b[i]*a, then brought back below n. Needs a < n.
// ----------------------------------------------------------------------------
module modexp_mm import modexp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mm_req_t              req,
	input  logic [WORD_BITS-1:0] n,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);

	localparam int EXT_BITS = WORD_BITS + 3;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] r_q;

	logic [EXT_BITS-1:0]  t;
	logic [EXT_BITS-1:0]  d1;
	logic [EXT_BITS-1:0]  d2;
	logic [WORD_BITS-1:0] r_next;

	// One step: shift, add, and subtract n at most twice (t < 3n)
	always_comb begin
		t = {2'b00, r_q, 1'b0} + (b_q[WORD_BITS-1] ? {3'b000, a_q} : '0);
		d1 = t - {3'b000, n};
		d2 = t - {2'b00, n, 1'b0};
		if (!d2[EXT_BITS-1]) begin
			r_next = d2[WORD_BITS-1:0];
		end else if (!d1[EXT_BITS-1]) begin
			r_next = d1[WORD_BITS-1:0];
		end else begin
			r_next = t[WORD_BITS-1:0];
		end
	end

	// Control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: operands and partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[WORD_BITS-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

// ===== src/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes message^exponent mod modulus by right-to-left square and multiply.
// ----------------------------------------------------------------------------
// One message is worked on at a time. An item first has its message reduced
// mod the modulus, then walks the exponent from its LSB up to its highest
// set bit: each bit costs one modular square and, when set, one modular
// multiply. The work is paced by the bit-serial modular multiplier that
// handles one multiplier bit per cycle. A zero exponent returns 1 (not
// reduced) and a zero modulus returns 0 with modulus_error set. The next
// message is taken while a finished result waits in the output register.
module modular_exponentiation import modexp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]   cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [FIELD_BITS-1:0]   message,
	// output channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [FIELD_BITS-1:0]   cipher_value,
	output logic                    modulus_error
);

	state_t state_q, state_d;

	logic [FIELD_BITS-1:0] exponent_q;
	logic [FIELD_BITS-1:0] modulus_q;

	logic [WORD_BITS-1:0]  base_q;
	logic [WORD_BITS-1:0]  acc_q;
	logic [WORD_BITS-1:0]  exp_q;
	logic                  err_q;

	logic                  out_valid_q;
	logic [FIELD_BITS-1:0] cipher_q;
	logic                  moderr_q;

	logic [WORD_BITS-1:0]  n_w;
	logic [WORD_BITS-1:0]  msg_w;
	logic [WORD_BITS-1:0]  exp_w;
	logic                  in_beat;
	logic                  out_load;

	mm_req_t               mm_req;
	logic                  mm_done;
	logic [WORD_BITS-1:0]  mm_result;

	assign n_w   = modulus_q[WORD_BITS-1:0];
	assign msg_w = message[WORD_BITS-1:0];
	assign exp_w = exponent_q[WORD_BITS-1:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= FIELD_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPONENT: exponent_q <= cfg_data;
				CFG_MODULUS:  modulus_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	modexp_mm u_mm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.n      (n_w),
		.done   (mm_done),
		.result (mm_result)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (n_w == '0 || exp_w == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mm_done) state_d = ST_BIT;
			end
			ST_BIT: begin
				if (exp_q == '0) begin
					state_d = ST_DONE;
				end else if (exp_q[0]) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_done) state_d = ST_SQR;
			end
			ST_SQR: begin
				if (mm_done) state_d = ST_BIT;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and multiplier requests
	always_comb begin
		in_ready     = 1'b0;
		out_load     = 1'b0;
		mm_req.start = 1'b0;
		mm_req.a     = base_q;
		mm_req.b     = base_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// message mod n, computed as 1 * message
				mm_req.start = in_valid && n_w != '0 && exp_w != '0;
				mm_req.a     = WORD_BITS'(1);
				mm_req.b     = msg_w;
			end
			ST_BIT: begin
				mm_req.start = exp_q != '0;
				if (exp_q[0]) mm_req.b = acc_q;
			end
			ST_MUL: begin
				// square follows the multiply at once
				mm_req.start = mm_done;
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	assign in_beat = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					exp_q <= exp_w;
					err_q <= n_w == '0;
					acc_q <= (n_w == '0) ? '0 : WORD_BITS'(1);
				end
			end
			ST_REDUCE: begin
				if (mm_done) base_q <= mm_result;
			end
			ST_MUL: begin
				if (mm_done) acc_q <= mm_result;
			end
			ST_SQR: begin
				if (mm_done) begin
					base_q <= mm_result;
					exp_q  <= exp_q >> 1;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cipher_q <= FIELD_BITS'(acc_q);
			moderr_q <= err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign cipher_value  = cipher_q;
	assign modulus_error = moderr_q;

endmodule

// ===== src/modexp_chk.sv =====
// ----------------------------------------------------------------------------
// modexp_chk
// Port-level checker for modular_exponentiation, bound to the top level.
// ----------------------------------------------------------------------------
module modexp_chk import modexp_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [FIELD_BITS-1:0]   cfg_data,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [FIELD_BITS-1:0]   cipher_value,
	input logic                    modulus_error
);

	logic [WORD_BITS-1:0] exp_sh_q;
	logic [WORD_BITS-1:0] mod_sh_q;
	logic [1:0]           pend_q;
	logic                 in_beat;
	logic                 out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Shadow of the configuration and count of beats in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_sh_q <= '0;
			mod_sh_q <= WORD_BITS'(1);
			pend_q   <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_EXPONENT) exp_sh_q <= cfg_data[WORD_BITS-1:0];
			if (cfg_we && cfg_index == CFG_MODULUS)  mod_sh_q <= cfg_data[WORD_BITS-1:0];
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_value)
			&& $stable(modulus_error))
		else $error("output beat changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("output beat without an accepted input");

	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> modulus_error == (mod_sh_q == '0))
		else $error("modulus_error does not match the modulus");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && modulus_error |-> cipher_value == '0)
		else $error("nonzero result with modulus error");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !modulus_error && exp_sh_q != '0
			|-> cipher_value < FIELD_BITS'(mod_sh_q))
		else $error("result not reduced below the modulus");

endmodule

bind modular_exponentiation modexp_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.cipher_value  (cipher_value),
	.modulus_error (modulus_error)
);
